// File: hw/rtl/smbus_block_pec_framer_core_defines.svh
// Assertion helpers used by the framer core.
`ifndef SMBUS_BLOCK_PEC_FRAMER_CORE_DEFINES_SVH
`define SMBUS_BLOCK_PEC_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SBPF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SBPF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/smbus_bpf_pkg.sv
package smbus_bpf_pkg;

    // Largest SMBus block
    localparam int MAX_BLOCK = 32;
    localparam logic [7:0] MAX_BLOCK_B = 8'(MAX_BLOCK);
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    // CRC-8 polynomial x^8+x^2+x+1, top bit implied
    localparam logic [7:0] PEC_POLY = 8'h07;

    // Results one input item can produce
    localparam int RES_MAX = 3;
    localparam int RCNT_W = $clog2(RES_MAX + 1);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SLAVE_ADDRESS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_CODE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PEC_ENABLE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CALLER_LENGTH = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BUF_SMALL = 2'd3
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [6:0] slave_address;
        logic [7:0] command_code;
        logic       pec_enable;
        logic [7:0] caller_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        t_status    status;
        logic       last;
    } t_result;

    // One queue entry: the results of one input item, slot 0 first
    typedef struct packed {
        t_result [RES_MAX-1:0] res;
        logic [RCNT_W-1:0]     cnt;
    } t_entry;

    // Front status seen by the top level
    typedef struct packed {
        logic seeding;
        logic push;
    } t_front_stat;

    // Queue status
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_queue_stat;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ PEC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic t_result byte_res(input logic [7:0] b, input logic last);
        t_result r;
        r.out_byte = b;
        r.is_status = 1'b0;
        r.status = ST_OK;
        r.last = last;
        return r;
    endfunction

    function automatic t_result stat_res(input t_status st);
        t_result r;
        r.out_byte = 8'd0;
        r.is_status = 1'b1;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

// File: hw/rtl/smbus_bpf_in_if.sv
interface smbus_bpf_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] data_byte;

    modport source (output valid, output start_req, output data_byte, input ready);
    modport sink (input valid, input start_req, input data_byte, output ready);
endinterface

// File: hw/rtl/smbus_bpf_out_if.sv
interface smbus_bpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output is_status, output status,
                    output last, input ready);
    modport sink (input valid, input out_byte, input is_status, input status,
                  input last, output ready);
endinterface

// File: hw/rtl/smbus_block_pec_framer_core.sv
// SMBus block write framer and block read checker with CRC-8 PEC.
// i_item carries input items (start_req, data_byte); o_res carries result
// transfers (out_byte, is_status, status, last). Both use valid/ready and
// move a transfer on a rising edge with both high. The APB port sets mode,
// slave_address, command_code, pec_enable and caller_length at 4*index.
// A start item, unless its write length is over the limit, holds
// i_item.ready low while the front builds the PEC seed in phases SEED1 and
// SEED2, one byte per cycle, though a full queue can hold SEED2 of a write.
// Results pass through the queue and then the back's output register, and
// leave from that register at one per cycle while o_res.ready is high.
// A two-entry queue between front and back lets intake continue while the
// receiver stalls; outside the seed cycles i_item.ready drops only when that
// queue is full. Synchronous reset clears the configuration, the phase, the
// PEC and the byte counters and empties the queue; no clearing pass is needed.
`include "smbus_block_pec_framer_core_defines.svh"

module smbus_block_pec_framer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    smbus_bpf_in_if.sink                        i_item,
    smbus_bpf_out_if.source                     o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smbus_bpf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import smbus_bpf_pkg::*;

    t_cfg                 r_cfg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 push;
    logic                 pop;
    t_entry               entry;
    t_entry               head;
    t_front_stat          fstat;
    t_queue_stat          qstat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE:          r_cfg.mode <= pwdata[0];
                REG_SLAVE_ADDRESS: r_cfg.slave_address <= pwdata[6:0];
                REG_COMMAND_CODE:  r_cfg.command_code <= pwdata[7:0];
                REG_PEC_ENABLE:    r_cfg.pec_enable <= pwdata[0];
                REG_CALLER_LENGTH: r_cfg.caller_length <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (reg_idx)
            REG_MODE:          prdata = {31'd0, r_cfg.mode};
            REG_SLAVE_ADDRESS: prdata = {25'd0, r_cfg.slave_address};
            REG_COMMAND_CODE:  prdata = {24'd0, r_cfg.command_code};
            REG_PEC_ENABLE:    prdata = {31'd0, r_cfg.pec_enable};
            REG_CALLER_LENGTH: prdata = {24'd0, r_cfg.caller_length};
            default:           prdata = 32'd0;
        endcase
    end

    smbus_bpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_entry (entry),
        .o_stat  (fstat)
    );

    smbus_bpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    smbus_bpf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    `SBPF_ASSERT_NOW(a_no_intake_while_seeding, i_clk, i_rst_n, fstat.seeding, !i_item.ready, "item taken while PEC seed in progress")
    `SBPF_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, fstat.push, !qstat.full, "queue overflow")
    `SBPF_ASSERT_NEXT(a_queued_work_offered, i_clk, i_rst_n, qstat.nonempty, o_res.valid, "queued results not offered")

endmodule

// File: hw/rtl/smbus_bpf_front.sv
module smbus_bpf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    smbus_bpf_in_if.sink               i_item,
    input  smbus_bpf_pkg::t_cfg        i_cfg,
    input  smbus_bpf_pkg::t_queue_stat i_qstat,
    output logic                       o_push,
    output smbus_bpf_pkg::t_entry      o_entry,
    output smbus_bpf_pkg::t_front_stat o_stat
);
    import smbus_bpf_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEED1,
        PH_SEED2,
        PH_WDATA,
        PH_RCOUNT,
        PH_RDATA,
        PH_RPEC
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_pec, n_pec;
    logic [CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [CNT_W-1:0] r_blk_cnt, n_blk_cnt;
    // Start-time copy of the registers used while seeding
    logic             r_mode_s, n_mode_s;
    logic [6:0]       r_addr_s, n_addr_s;
    logic [7:0]       r_cmd_s, n_cmd_s;
    logic [7:0]       r_len_s, n_len_s;
    logic             r_pen_s, n_pen_s;

    logic             seeding;
    logic             acc;
    logic             push;
    t_entry           ent;
    logic [7:0]       d;
    logic [7:0]       d_pec;
    logic [7:0]       seed_byte;
    logic [7:0]       seed_pec;
    logic [CNT_W-1:0] cnt_inc;

    // Block intake while the PEC seed is built or the queue is full
    assign seeding = (r_phase == PH_SEED1) || (r_phase == PH_SEED2);
    assign i_item.ready = !seeding && !i_qstat.full;
    assign acc = i_item.valid && i_item.ready;

    assign d = i_item.data_byte;
    assign d_pec = crc8_byte(r_pec, d);
    assign cnt_inc = r_byte_cnt + 1'b1;
    assign seed_byte = r_mode_s ? {r_addr_s, 1'b1} : r_len_s;
    assign seed_pec = crc8_byte(r_pec, seed_byte);

    // Classify the item and build its results
    always_comb begin
        n_phase = r_phase;
        n_pec = r_pec;
        n_byte_cnt = r_byte_cnt;
        n_blk_cnt = r_blk_cnt;
        n_mode_s = r_mode_s;
        n_addr_s = r_addr_s;
        n_cmd_s = r_cmd_s;
        n_len_s = r_len_s;
        n_pen_s = r_pen_s;
        push = 1'b0;
        ent = '0;
        if (acc && i_item.start_req) begin
            n_byte_cnt = '0;
            n_mode_s = i_cfg.mode;
            n_addr_s = i_cfg.slave_address;
            n_cmd_s = i_cfg.command_code;
            n_len_s = i_cfg.caller_length;
            n_pen_s = i_cfg.pec_enable;
            if (!i_cfg.mode && (i_cfg.caller_length > MAX_BLOCK_B)) begin
                ent.res[0] = stat_res(ST_BAD_LEN);
                ent.cnt = RCNT_W'(1);
                push = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                n_pec = crc8_byte(8'd0, {i_cfg.slave_address, 1'b0});
                n_phase = PH_SEED1;
            end
        end else begin
            unique case (r_phase)
                PH_SEED1: begin
                    n_pec = crc8_byte(r_pec, r_cmd_s);
                    n_phase = PH_SEED2;
                end
                PH_SEED2: begin
                    if (r_mode_s) begin
                        n_pec = seed_pec;
                        n_blk_cnt = '0;
                        n_phase = PH_RCOUNT;
                    end else if (!i_qstat.full) begin
                        // Command and length, then close a zero-length write
                        n_pec = seed_pec;
                        n_blk_cnt = r_len_s[CNT_W-1:0];
                        ent.res[0] = byte_res(r_cmd_s, 1'b0);
                        ent.res[1] = byte_res(r_len_s, 1'b0);
                        push = 1'b1;
                        if (r_len_s == 8'd0) begin
                            ent.res[2] = r_pen_s ? byte_res(seed_pec, 1'b1) : stat_res(ST_OK);
                            ent.cnt = RCNT_W'(3);
                            n_phase = PH_IDLE;
                        end else begin
                            ent.cnt = RCNT_W'(2);
                            n_phase = PH_WDATA;
                        end
                    end
                end
                PH_WDATA: begin
                    if (acc) begin
                        n_pec = d_pec;
                        n_byte_cnt = cnt_inc;
                        ent.res[0] = byte_res(d, 1'b0);
                        ent.cnt = RCNT_W'(1);
                        push = 1'b1;
                        if (cnt_inc >= r_blk_cnt) begin
                            if (i_cfg.pec_enable) begin
                                ent.res[1] = byte_res(d_pec, 1'b0);
                                ent.res[2] = stat_res(ST_OK);
                                ent.cnt = RCNT_W'(3);
                            end else begin
                                ent.res[1] = stat_res(ST_OK);
                                ent.cnt = RCNT_W'(2);
                            end
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_RCOUNT: begin
                    if (acc) begin
                        if ((d == 8'd0) || (d > MAX_BLOCK_B)) begin
                            ent.res[0] = stat_res(ST_BAD_LEN);
                            ent.cnt = RCNT_W'(1);
                            push = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (d > i_cfg.caller_length) begin
                            // Skip the PEC check: the frame was not fully read
                            ent.res[0] = stat_res(ST_BUF_SMALL);
                            ent.cnt = RCNT_W'(1);
                            push = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_pec = d_pec;
                            n_blk_cnt = d[CNT_W-1:0];
                            n_byte_cnt = '0;
                            n_phase = PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    if (acc) begin
                        n_pec = d_pec;
                        n_byte_cnt = cnt_inc;
                        ent.res[0] = byte_res(d, 1'b0);
                        ent.cnt = RCNT_W'(1);
                        push = 1'b1;
                        if (cnt_inc >= r_blk_cnt) begin
                            if (i_cfg.pec_enable) begin
                                n_phase = PH_RPEC;
                            end else begin
                                ent.res[1] = stat_res(ST_OK);
                                ent.cnt = RCNT_W'(2);
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                end
                PH_RPEC: begin
                    if (acc) begin
                        ent.res[0] = stat_res((d == r_pec) ? ST_OK : ST_CRC_ERR);
                        ent.cnt = RCNT_W'(1);
                        push = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    // Drop data items outside a transaction
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Hold phase and working values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pec <= '0;
            r_byte_cnt <= '0;
            r_blk_cnt <= '0;
        end else begin
            r_phase <= n_phase;
            r_pec <= n_pec;
            r_byte_cnt <= n_byte_cnt;
            r_blk_cnt <= n_blk_cnt;
        end
        r_mode_s <= n_mode_s;
        r_addr_s <= n_addr_s;
        r_cmd_s <= n_cmd_s;
        r_len_s <= n_len_s;
        r_pen_s <= n_pen_s;
    end

    assign o_push = push;
    assign o_entry = ent;
    assign o_stat.seeding = seeding;
    assign o_stat.push = push;

endmodule

// File: hw/rtl/smbus_bpf_queue.sv
module smbus_bpf_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  smbus_bpf_pkg::t_entry      i_entry,
    input  logic                       i_pop,
    output smbus_bpf_pkg::t_entry      o_head,
    output smbus_bpf_pkg::t_queue_stat o_stat
);
    import smbus_bpf_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign do_push = i_push && (r_count != QCNT_W'(QDEPTH));
    assign do_pop = i_pop && (r_count != '0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head = r_mem[r_rd_ptr];
    assign o_stat.full = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.nonempty = (r_count != '0);

endmodule

// File: hw/rtl/smbus_bpf_back.sv
module smbus_bpf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  smbus_bpf_pkg::t_entry      i_head,
    input  smbus_bpf_pkg::t_queue_stat i_qstat,
    output logic                       o_pop,
    smbus_bpf_out_if.source            o_res
);
    import smbus_bpf_pkg::*;

    logic              r_busy;
    t_entry            r_ent;
    logic [RCNT_W-1:0] r_idx;
    t_result           cur;
    logic              xfer;
    logic              at_end;
    logic              pop;

    // Select the result slot being offered
    always_comb begin
        case (r_idx)
            RCNT_W'(0): cur = r_ent.res[0];
            RCNT_W'(1): cur = r_ent.res[1];
            RCNT_W'(2): cur = r_ent.res[2];
            default:    cur = r_ent.res[0];
        endcase
    end

    assign xfer = r_busy && o_res.ready;
    assign at_end = (r_idx == (r_ent.cnt - 1'b1));
    assign pop = i_qstat.nonempty && (!r_busy || (xfer && at_end));

    // Load the next entry or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
        end else if (pop) begin
            r_busy <= 1'b1;
            r_idx <= '0;
        end else if (xfer) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (pop) begin
            r_ent <= i_head;
        end
    end

    assign o_pop = pop;
    assign o_res.valid = r_busy;
    assign o_res.out_byte = cur.out_byte;
    assign o_res.is_status = cur.is_status;
    assign o_res.status = cur.status;
    assign o_res.last = cur.last;

endmodule

// File: dv/tb_smbus_block_pec_framer_core.sv
module tb_smbus_block_pec_framer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import smbus_bpf_pkg::*;

    localparam int unsigned STALL_MAX      = 16;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned ITEM_TARGET    = 300;
    localparam logic [7:0]  CRC_POLY       = 8'h07;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WR_DATA,
        PH_RD_COUNT,
        PH_RD_DATA,
        PH_RD_PEC
    } t_frame_phase;

    // Mirror of the framer: register copy, PEC and phase, plus the results still due
    class t_pec_frame_scoreboard;
        t_cfg         cfg;
        logic [7:0]   crc;
        logic [5:0]   byte_idx;
        logic [5:0]   blk_len;
        t_frame_phase ph;
        t_result      due_results[$];
        int unsigned  mismatches;

        function new();
            cfg        = '0;
            crc        = '0;
            byte_idx   = '0;
            blk_len    = '0;
            ph         = PH_IDLE;
            mismatches = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                REG_MODE:          cfg.mode          = v[0];
                REG_SLAVE_ADDRESS: cfg.slave_address = v[6:0];
                REG_COMMAND_CODE:  cfg.command_code  = v[7:0];
                REG_PEC_ENABLE:    cfg.pec_enable    = v[0];
                REG_CALLER_LENGTH: cfg.caller_length = v[7:0];
                default: ;
            endcase
        endfunction

        // CRC-8, one message bit at a time, MSB first
        static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0};
                if (fb) c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void queue_byte(logic [7:0] b, logic last);
            t_result r;
            r.out_byte  = b;
            r.is_status = 1'b0;
            r.status    = ST_OK;
            r.last      = last;
            due_results.push_back(r);
        endfunction

        function void queue_status(t_status s);
            t_result r;
            r.out_byte  = 8'h00;
            r.is_status = 1'b1;
            r.status    = s;
            r.last      = 1'b1;
            due_results.push_back(r);
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        // Advance on one accepted item; returns 0 when the item is ignored
        function bit take_item(logic st, logic [7:0] d);
            logic [7:0] aw;
            bit         live;
            aw   = {cfg.slave_address, 1'b0};
            live = st || (ph != PH_IDLE);
            if (st) begin
                byte_idx = '0;
                if (!cfg.mode) begin
                    if (cfg.caller_length > MAX_BLOCK_B) begin
                        queue_status(ST_BAD_LEN);
                        ph = PH_IDLE;
                    end else begin
                        crc = crc_step(crc_step(crc_step(8'h00, aw), cfg.command_code),
                                       cfg.caller_length);
                        blk_len = cfg.caller_length[5:0];
                        queue_byte(cfg.command_code, 1'b0);
                        queue_byte(cfg.caller_length, 1'b0);
                        if (cfg.caller_length == 8'd0) begin
                            // empty write: PEC closes the frame, else an OK status does
                            if (cfg.pec_enable) queue_byte(crc, 1'b1);
                            else queue_status(ST_OK);
                            ph = PH_IDLE;
                        end else begin
                            ph = PH_WR_DATA;
                        end
                    end
                end else begin
                    // seed covers address+W, command and address+R, nothing emitted
                    crc = crc_step(crc_step(crc_step(8'h00, aw), cfg.command_code),
                                   aw | 8'h01);
                    blk_len = '0;
                    ph      = PH_RD_COUNT;
                end
            end else begin
                case (ph)
                    PH_WR_DATA: begin
                        queue_byte(d, 1'b0);
                        crc = crc_step(crc, d);
                        byte_idx++;
                        if (byte_idx >= blk_len) begin
                            if (cfg.pec_enable) queue_byte(crc, 1'b0);
                            queue_status(ST_OK);
                            ph = PH_IDLE;
                        end
                    end
                    PH_RD_COUNT: begin
                        if (d == 8'd0 || d > MAX_BLOCK_B) begin
                            queue_status(ST_BAD_LEN);
                            ph = PH_IDLE;
                        end else if (d > cfg.caller_length) begin
                            // no PEC check: the rest of the block never arrives
                            queue_status(ST_BUF_SMALL);
                            ph = PH_IDLE;
                        end else begin
                            crc      = crc_step(crc, d);
                            blk_len  = d[5:0];
                            byte_idx = '0;
                            ph       = PH_RD_DATA;
                        end
                    end
                    PH_RD_DATA: begin
                        queue_byte(d, 1'b0);
                        crc = crc_step(crc, d);
                        byte_idx++;
                        if (byte_idx >= blk_len) begin
                            if (cfg.pec_enable) begin
                                ph = PH_RD_PEC;
                            end else begin
                                queue_status(ST_OK);
                                ph = PH_IDLE;
                            end
                        end
                    end
                    PH_RD_PEC: begin
                        queue_status((d == crc) ? ST_OK : ST_CRC_ERR);
                        ph = PH_IDLE;
                    end
                    default: ph = PH_IDLE;
                endcase
            end
            return live;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %02h flag %0b status %0d last %0b",
                             got.out_byte, got.is_status, got.status, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.out_byte !== want.out_byte || got.is_status !== want.is_status ||
                got.status !== want.status || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected byte %02h flag %0b status %0d last %0b, got byte %02h flag %0b status %0d last %0b",
                             want.out_byte, want.is_status, want.status, want.last,
                             got.out_byte, got.is_status, got.status, got.last);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    smbus_bpf_in_if  item_if ();
    smbus_bpf_out_if res_if ();

    smbus_block_pec_framer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_pec_frame_scoreboard sb;
    bit                    src_burst = 1'b0;
    bit                    snk_burst = 1'b0;
    int unsigned           live_items = 0;
    int unsigned           quiet_cycles = 0;

    always #5ns i_clk = ~i_clk;

    // Drive one item after a random gap; hold valid high across back-to-back transfers
    task automatic send_item(input logic st, input logic [7:0] d);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap != 0) begin
            @(negedge i_clk);
            item_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_if.valid     <= 1'b1;
        item_if.start_req <= st;
        item_if.data_byte <= d;
        do @(posedge i_clk); while (!item_if.ready);
        if (sb.take_item(st, d)) live_items++;
    endtask

    // Drop valid and let every due result drain, then allow for silent work
    task automatic settle();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic m, input logic [6:0] a, input logic [7:0] c,
                             input logic p, input logic [7:0] len);
        settle();
        reg_write(REG_MODE, 32'(m));
        reg_write(REG_SLAVE_ADDRESS, 32'(a));
        reg_write(REG_COMMAND_CODE, 32'(c));
        reg_write(REG_PEC_ENABLE, 32'(p));
        reg_write(REG_CALLER_LENGTH, 32'(len));
    endtask

    function automatic int unsigned pick_value(int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 0;
        if (r == 1) return hi;
        return $urandom_range(0, hi);
    endfunction

    // Mostly short blocks, some long ones, a few over the SMBus limit
    function automatic logic [7:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'($urandom_range(0, 8));
        if (r < 8) return 8'($urandom_range(9, MAX_BLOCK));
        if (r == 8) return MAX_BLOCK_B;
        return $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(MAX_BLOCK + 1, 254));
    endfunction

    // Block write: start, then the payload, now and then cut short
    task automatic write_frame();
        int unsigned n;
        send_item(1'b1, 8'($urandom));
        n = (sb.ph == PH_WR_DATA) ? sb.blk_len : 0;
        if (n != 0 && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
        repeat (n) send_item(1'b0, 8'($urandom));
    endtask

    // Block read: start, count, data and PEC, the PEC sometimes corrupted
    task automatic read_frame();
        int unsigned lim;
        int unsigned r;
        logic [7:0]  cnt;
        lim = (sb.cfg.caller_length > MAX_BLOCK) ? MAX_BLOCK : sb.cfg.caller_length;
        r   = $urandom_range(0, 9);
        if (r < 7)
            cnt = (lim == 0) ? 8'($urandom) : 8'($urandom_range(1, lim));
        else if (r == 7)
            cnt = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_BLOCK + 1, 255));
        else if (r == 8)
            cnt = 8'($urandom_range(lim + 1, MAX_BLOCK + 1));
        else
            cnt = 8'($urandom);
        send_item(1'b1, 8'($urandom));
        send_item(1'b0, cnt);
        if (sb.ph == PH_RD_DATA) repeat (cnt) send_item(1'b0, 8'($urandom));
        if (sb.ph == PH_RD_PEC)
            send_item(1'b0, ($urandom_range(0, 4) == 0) ?
                            sb.crc ^ 8'($urandom_range(1, 255)) : sb.crc);
    endtask

    // Result side: check each transfer, then stall ready for a random spell
    initial begin
        t_result     seen;
        int unsigned snk_wait;
        snk_wait = 0;
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                seen.out_byte  = res_if.out_byte;
                seen.is_status = res_if.is_status;
                seen.status    = t_status'(res_if.status);
                seen.last      = res_if.last;
                sb.check_result(seen);
                snk_wait = snk_burst ? 0 : $urandom_range(0, STALL_MAX);
            end
            @(negedge i_clk);
            if (snk_wait != 0) begin
                res_if.ready <= 1'b0;
                snk_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned kind;
        sb = new();
        i_rst_n           <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.start_req <= 1'b0;
        item_if.data_byte <= 8'h00;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty write with PEC: command, length, PEC as last
        configure(1'b0, 7'h7F, 8'hFF, 1'b1, 8'd0);
        send_item(1'b1, 8'hFF);
        // Empty write without PEC, then a data item while idle
        configure(1'b0, 7'h7F, 8'hFF, 1'b0, 8'd0);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hA5);
        // Write length over the limit
        configure(1'b0, 7'h00, 8'h00, 1'b1, 8'hFF);
        send_item(1'b1, 8'h00);
        // Restart in the middle of a write, then a full one
        configure(1'b0, 7'h00, 8'h00, 1'b1, 8'd2);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h80);
        // Reads: zero count, count over the limit, count over the buffer,
        // good PEC, bad PEC
        configure(1'b1, 7'h55, 8'h0A, 1'b1, 8'd8);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h09);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h02);
        send_item(1'b0, 8'hAA);
        send_item(1'b0, 8'h55);
        send_item(1'b0, sb.crc);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h01);
        send_item(1'b0, 8'h3C);
        send_item(1'b0, ~sb.crc);

        // Random phases: fresh registers, then mostly well-formed frames with noise
        while (live_items < ITEM_TARGET) begin
            configure(1'($urandom_range(0, 1)), 7'(pick_value(127)), 8'(pick_value(255)),
                      1'($urandom_range(0, 1)), pick_len());
            src_burst = ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) begin
                kind = $urandom_range(0, 9);
                if (kind >= 8) begin
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(0, 5) == 0), 8'($urandom));
                end else if (sb.cfg.mode) begin
                    read_frame();
                end else begin
                    write_frame();
                end
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/smbus_bpf_pkg.sv
hw/rtl/smbus_bpf_in_if.sv
hw/rtl/smbus_bpf_out_if.sv
hw/rtl/smbus_bpf_front.sv
hw/rtl/smbus_bpf_queue.sv
hw/rtl/smbus_bpf_back.sv
hw/rtl/smbus_block_pec_framer_core.sv
dv/tb_smbus_block_pec_framer_core.sv
